>>> hdl/lbhc_pkg.sv
// Shared types and constants of the LED blink and heartbeat controller.
`default_nettype none

package lbhc_pkg;

  localparam int unsigned OpWidth   = 3;
  localparam int unsigned SelWidth  = 2;
  localparam int unsigned CountWidth = 16;
  localparam int unsigned BlinkWidth = 15;
  localparam int unsigned PulseWidth = 14;
  localparam int unsigned PauseWidth = 14;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 15;
  localparam int unsigned LitWidth  = 4;

  localparam logic [OpWidth-1:0] OP_TICK  = 3'd0;
  localparam logic [OpWidth-1:0] OP_ON    = 3'd1;
  localparam logic [OpWidth-1:0] OP_OFF   = 3'd2;
  localparam logic [OpWidth-1:0] OP_BLINK = 3'd3;
  localparam logic [OpWidth-1:0] OP_HEART = 3'd4;

  localparam logic [CfgIdxWidth-1:0] CFG_BLINK_HALF = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_PULSE      = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_PAUSE      = 2'd2;

  localparam logic [BlinkWidth-1:0] BLINK_HALF_RESET = 15'd125;
  localparam logic [PulseWidth-1:0] PULSE_RESET      = 14'd25;
  localparam logic [PauseWidth-1:0] PAUSE_RESET      = 14'd175;

  typedef enum logic [OpWidth-1:0] {
    MODE_IDLE  = 3'd0,
    MODE_ON    = 3'd1,
    MODE_OFF   = 3'd2,
    MODE_BLINK = 3'd3,
    MODE_HEART = 3'd4
  } mode_e;

endpackage

`default_nettype wire

>>> hdl/led_blink_heartbeat_controller.sv
// Top level of the LED blink and heartbeat controller.
`default_nettype none

// Drives NUM_LEDS LEDs in on, off, blink or heartbeat patterns. Each input item is
// a tick, which advances every LED at once, or a command for the LED that
// led_select_i names. Every item yields one result item with the lit flags of
// LEDs zero to three as they stand after it. The per-LED counters and flags
// update at the accepting edge, and the result sits in an output register, so a
// new item is taken in every cycle while the result side keeps up. Configuration
// writes take effect at the edge of the write.
module led_blink_heartbeat_controller #(
  parameter int unsigned NUM_LEDS = 4
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [lbhc_pkg::OpWidth-1:0]          operation_i,
  input  wire logic [lbhc_pkg::SelWidth-1:0]         led_select_i,
  input  wire logic [lbhc_pkg::CountWidth-1:0]       repeat_limit_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic [lbhc_pkg::LitWidth-1:0]              led_lit_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic [lbhc_pkg::CfgIdxWidth-1:0]      cfg_index_i,
  input  wire logic [lbhc_pkg::CfgDataWidth-1:0]     cfg_data_i
);

  localparam int unsigned CW = lbhc_pkg::CountWidth;

  logic [lbhc_pkg::BlinkWidth-1:0] blink_half_q;
  logic [lbhc_pkg::PulseWidth-1:0] pulse_q;
  logic [lbhc_pkg::PauseWidth-1:0] pause_q;

  lbhc_pkg::mode_e mode_q [NUM_LEDS];
  lbhc_pkg::mode_e mode_d [NUM_LEDS];
  logic [CW-1:0]   tick_q [NUM_LEDS];
  logic [CW-1:0]   tick_d [NUM_LEDS];
  logic [CW-1:0]   rep_q  [NUM_LEDS];
  logic [CW-1:0]   rep_d  [NUM_LEDS];
  logic [CW-1:0]   goal_q [NUM_LEDS];
  logic [CW-1:0]   goal_d [NUM_LEDS];
  logic [NUM_LEDS-1:0] lit_q;
  logic [NUM_LEDS-1:0] lit_d;

  logic                             out_valid_q;
  logic [lbhc_pkg::LitWidth-1:0]    led_lit_q;
  logic [lbhc_pkg::LitWidth-1:0]    led_lit_d;

  logic          in_accept;
  logic          is_tick;
  logic          is_cmd;
  logic [CW:0]   blink_full;
  logic [CW:0]   pulse1;
  logic [CW:0]   pulse2;
  logic [CW:0]   pulse3;
  logic [CW:0]   heart_full;
  logic [CW-1:0] tick_inc;
  logic [CW:0]   tick_ext;
  logic          cycle_end;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;
  assign is_tick    = (operation_i == lbhc_pkg::OP_TICK);
  assign is_cmd     = (operation_i >= lbhc_pkg::OP_ON) && (operation_i <= lbhc_pkg::OP_HEART)
                      && (32'(led_select_i) < NUM_LEDS);

  assign blink_full = {1'b0, blink_half_q, 1'b0};
  assign pulse1     = {3'b0, pulse_q};
  assign pulse2     = {2'b0, pulse_q, 1'b0};
  assign pulse3     = pulse2 + pulse1;
  assign heart_full = pulse3 + {3'b0, pause_q};

  always_comb begin
    mode_d    = mode_q;
    tick_d    = tick_q;
    rep_d     = rep_q;
    goal_d    = goal_q;
    lit_d     = lit_q;
    tick_inc  = '0;
    tick_ext  = '0;
    cycle_end = 1'b0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      tick_inc  = tick_q[i] + 16'd1;
      tick_ext  = {1'b0, tick_inc};
      cycle_end = 1'b0;
      if (in_accept && is_tick) begin
        case (mode_q[i])
          lbhc_pkg::MODE_ON: begin
            mode_d[i] = lbhc_pkg::MODE_IDLE;
            lit_d[i]  = 1'b1;
          end
          lbhc_pkg::MODE_OFF: begin
            mode_d[i] = lbhc_pkg::MODE_IDLE;
            lit_d[i]  = 1'b0;
          end
          lbhc_pkg::MODE_BLINK, lbhc_pkg::MODE_HEART: begin
            tick_d[i] = tick_inc;
            if (tick_inc == 16'd1) begin
              rep_d[i] = rep_q[i] + 16'd1;
              lit_d[i] = 1'b1;
            end
            if (mode_q[i] == lbhc_pkg::MODE_BLINK) begin
              if (tick_ext == {2'b0, blink_half_q}) lit_d[i] = 1'b0;
              if (tick_ext == blink_full) cycle_end = 1'b1;
            end else begin
              if (tick_ext == pulse1) lit_d[i] = 1'b0;
              if (tick_ext == pulse2) lit_d[i] = 1'b1;
              if (tick_ext == pulse3) lit_d[i] = 1'b0;
              if (tick_ext == heart_full) cycle_end = 1'b1;
            end
            if (cycle_end) begin
              tick_d[i] = '0;
              if ((goal_q[i] != '0) && (rep_d[i] >= goal_q[i])) begin
                mode_d[i] = lbhc_pkg::MODE_OFF;
                goal_d[i] = '0;
                rep_d[i]  = '0;
              end
            end
          end
          default: begin
          end
        endcase
      end else if (in_accept && is_cmd && (32'(led_select_i) == i)) begin
        mode_d[i] = lbhc_pkg::mode_e'(operation_i);
        if ((operation_i == lbhc_pkg::OP_BLINK) || (operation_i == lbhc_pkg::OP_HEART)) begin
          goal_d[i] = repeat_limit_i;
        end
      end
    end
  end

  for (genvar b = 0; b < lbhc_pkg::LitWidth; b++) begin : g_lit
    if (b < NUM_LEDS) begin : g_led
      assign led_lit_d[b] = lit_d[b];
    end else begin : g_none
      assign led_lit_d[b] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_half_q <= lbhc_pkg::BLINK_HALF_RESET;
      pulse_q      <= lbhc_pkg::PULSE_RESET;
      pause_q      <= lbhc_pkg::PAUSE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lbhc_pkg::CFG_BLINK_HALF: blink_half_q <= cfg_data_i;
        lbhc_pkg::CFG_PULSE:      pulse_q      <= cfg_data_i[lbhc_pkg::PulseWidth-1:0];
        lbhc_pkg::CFG_PAUSE:      pause_q      <= cfg_data_i[lbhc_pkg::PauseWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        mode_q[i] <= lbhc_pkg::MODE_IDLE;
        tick_q[i] <= '0;
        rep_q[i]  <= '0;
        goal_q[i] <= '0;
      end
      lit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      tick_q <= tick_d;
      rep_q  <= rep_d;
      goal_q <= goal_d;
      lit_q  <= lit_d;
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      led_lit_q <= led_lit_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign led_lit_o   = led_lit_q;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_q)
    else $error("An accepted item did not produce a result.");

  a_result_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ready_i && !in_accept |=> !out_valid_q)
    else $error("A delivered result was shown again.");

  a_cmd_keeps_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !is_tick |=> $stable(lit_q))
    else $error("A command changed a lit flag before the next tick.");

  a_pending_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && is_tick && (mode_q[0] == lbhc_pkg::MODE_ON)
    |=> lit_q[0] && (mode_q[0] == lbhc_pkg::MODE_IDLE))
    else $error("A pending on was not applied by the tick.");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(lit_q) && $stable(tick_q[0]))
    else $error("LED state moved without an accepted item.");

endmodule

`default_nettype wire

>>> dv/led_blink_heartbeat_controller_tb.sv
// Testbench for the LED blink and heartbeat controller, checked against a pattern predictor.
module led_blink_heartbeat_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumLeds = 4;

  typedef logic [lbhc_pkg::OpWidth-1:0] op_t;
  typedef logic [lbhc_pkg::SelWidth-1:0] sel_t;
  typedef logic [lbhc_pkg::CountWidth-1:0] count_t;
  typedef logic [lbhc_pkg::CfgDataWidth-1:0] cfg_data_t;
  typedef logic [lbhc_pkg::LitWidth-1:0] lit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  op_t operation = lbhc_pkg::OP_TICK;
  sel_t led_select = '0;
  count_t repeat_limit = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lit_t led_lit;
  logic cfg_we = 1'b0;
  logic [lbhc_pkg::CfgIdxWidth-1:0] cfg_index = lbhc_pkg::CFG_BLINK_HALF;
  cfg_data_t cfg_data = '0;

  lbhc_pkg::mode_e led_mode [NumLeds];
  count_t tick_cnt [NumLeds];
  count_t repeat_cnt [NumLeds];
  count_t repeat_goal [NumLeds];
  logic led_on [NumLeds];
  logic [lbhc_pkg::BlinkWidth-1:0] half_period = lbhc_pkg::BLINK_HALF_RESET;
  logic [lbhc_pkg::PulseWidth-1:0] pulse_len = lbhc_pkg::PULSE_RESET;
  logic [lbhc_pkg::PauseWidth-1:0] pause_len = lbhc_pkg::PAUSE_RESET;
  lit_t lit_expected_q [$];
  lit_t lit_exp;

  int unsigned fault_count = 0;
  bit send_gaps = 1'b1;
  bit stall_gaps = 1'b1;

  always #5 clk = ~clk;

  led_blink_heartbeat_controller #(
    .NUM_LEDS(NumLeds)
  ) DUT (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .operation_i(operation),
    .led_select_i(led_select),
    .repeat_limit_i(repeat_limit),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .led_lit_o(led_lit),
    .cfg_we_i(cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  task automatic flag_fault(input string what);
    if (fault_count < 10) begin
      $display("%0t: %s", $time, what);
    end
    fault_count++;
  endtask

  task automatic close_cycle(input int unsigned idx);
    tick_cnt[idx] = '0;
    if (repeat_goal[idx] != 0 && repeat_cnt[idx] >= repeat_goal[idx]) begin
      led_mode[idx] = lbhc_pkg::MODE_OFF;
      repeat_goal[idx] = '0;
      repeat_cnt[idx] = '0;
    end
  endtask

  task automatic predict_leds(input op_t op, input sel_t sel, input count_t lim);
    int unsigned c;
    int unsigned half;
    int unsigned pulse;
    int unsigned pause;
    lit_t lit_vec;
    half = 32'(half_period);
    pulse = 32'(pulse_len);
    pause = 32'(pause_len);
    if (op == lbhc_pkg::OP_TICK) begin
      for (int i = 0; i < NumLeds; i++) begin
        case (led_mode[i])
          lbhc_pkg::MODE_ON: begin
            led_mode[i] = lbhc_pkg::MODE_IDLE;
            led_on[i] = 1'b1;
          end
          lbhc_pkg::MODE_OFF: begin
            led_mode[i] = lbhc_pkg::MODE_IDLE;
            led_on[i] = 1'b0;
          end
          lbhc_pkg::MODE_BLINK, lbhc_pkg::MODE_HEART: begin
            tick_cnt[i] = tick_cnt[i] + count_t'(1);
            c = 32'(tick_cnt[i]);
            if (c == 1) begin
              repeat_cnt[i] = repeat_cnt[i] + count_t'(1);
              led_on[i] = 1'b1;
            end
            if (led_mode[i] == lbhc_pkg::MODE_BLINK) begin
              if (c == half) led_on[i] = 1'b0;
              if (c == 2 * half) close_cycle(i);
            end else begin
              if (c == pulse) led_on[i] = 1'b0;
              if (c == 2 * pulse) led_on[i] = 1'b1;
              if (c == 3 * pulse) led_on[i] = 1'b0;
              if (c == 3 * pulse + pause) close_cycle(i);
            end
          end
          default: ;
        endcase
      end
    end else if (op <= lbhc_pkg::OP_HEART) begin
      led_mode[sel] = lbhc_pkg::mode_e'(op);
      if (op == lbhc_pkg::OP_BLINK || op == lbhc_pkg::OP_HEART) begin
        repeat_goal[sel] = lim;
      end
    end
    for (int i = 0; i < lbhc_pkg::LitWidth; i++) begin
      lit_vec[i] = led_on[i];
    end
    lit_expected_q.push_back(lit_vec);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (lit_expected_q.size() == 0) begin
        flag_fault($sformatf("result %h arrived with no item outstanding", led_lit));
      end else begin
        lit_exp = lit_expected_q.pop_front();
        if (led_lit !== lit_exp) begin
          flag_fault($sformatf("led_lit expected %h got %h", lit_exp, led_lit));
        end
      end
    end
    out_ready <= stall_gaps ? ($urandom_range(99) >= 32) : 1'b1;
  end

  task automatic send_item(input op_t op, input sel_t sel, input count_t lim);
    while (send_gaps && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    led_select <= sel;
    repeat_limit <= lim;
    do @(posedge clk); while (!in_ready);
    predict_leds(op, sel, lim);
  endtask

  task automatic send_random_items(input int unsigned count);
    op_t op;
    count_t lim;
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 58) begin
        op = lbhc_pkg::OP_TICK;
      end else if (pick < 95) begin
        op = op_t'($urandom_range(lbhc_pkg::OP_ON, lbhc_pkg::OP_HEART));
      end else begin
        op = op_t'($urandom_range(lbhc_pkg::OP_HEART + 1, {lbhc_pkg::OpWidth{1'b1}}));
      end
      pick = $urandom_range(99);
      if (pick < 75) begin
        lim = count_t'($urandom_range(0, 4));
      end else begin
        lim = count_t'($urandom());
      end
      send_item(op, sel_t'($urandom_range(NumLeds - 1)), lim);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (lit_expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_registers(input cfg_data_t half_val, input cfg_data_t pulse_val,
                                 input cfg_data_t pause_val);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= lbhc_pkg::CFG_BLINK_HALF;
    cfg_data <= half_val;
    @(posedge clk);
    half_period = half_val[lbhc_pkg::BlinkWidth-1:0];
    cfg_index <= lbhc_pkg::CFG_PULSE;
    cfg_data <= pulse_val;
    @(posedge clk);
    pulse_len = pulse_val[lbhc_pkg::PulseWidth-1:0];
    cfg_index <= lbhc_pkg::CFG_PAUSE;
    cfg_data <= pause_val;
    @(posedge clk);
    pause_len = pause_val[lbhc_pkg::PauseWidth-1:0];
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_item(lbhc_pkg::OP_TICK, 2'd3, 16'hFFFF);
    send_item(op_t'(lbhc_pkg::OP_HEART + 1), 2'd0, 16'hFFFF);
    send_item(op_t'(lbhc_pkg::OP_HEART + 2), 2'd2, 16'h0000);
    send_item('1, 2'd3, 16'hFFFF);
    for (int i = 0; i < NumLeds; i++) begin
      send_item(lbhc_pkg::OP_ON, sel_t'(i), 16'hFFFF);
    end
    send_item(lbhc_pkg::OP_TICK, 2'd0, '0);
    send_item(lbhc_pkg::OP_OFF, 2'd2, 16'hFFFF);
    send_item(lbhc_pkg::OP_ON, 2'd0, '0);
    send_item(lbhc_pkg::OP_OFF, 2'd0, '0);
    send_item(lbhc_pkg::OP_TICK, 2'd1, '0);
    send_item(lbhc_pkg::OP_HEART, 2'd3, 16'd1);
    send_item(lbhc_pkg::OP_TICK, 2'd0, '0);
  endtask

  task automatic test_short_cycles();
    write_registers(15'd2, 15'd1, 15'd0);
    send_item(lbhc_pkg::OP_BLINK, 2'd0, 16'd2);
    send_item(lbhc_pkg::OP_HEART, 2'd1, 16'd1);
    send_item(lbhc_pkg::OP_BLINK, 2'd2, 16'd0);
    send_item(lbhc_pkg::OP_HEART, 2'd3, 16'hFFFF);
    repeat (10) send_item(lbhc_pkg::OP_TICK, '0, '0);
    write_registers(15'd1, 15'd2, 15'd3);
    send_item(lbhc_pkg::OP_BLINK, 2'd0, 16'd1);
    repeat (4) send_item(lbhc_pkg::OP_TICK, '0, '0);
  endtask

  task automatic test_register_extremes();
    write_registers({lbhc_pkg::CfgDataWidth{1'b1}}, {lbhc_pkg::CfgDataWidth{1'b1}},
                    {lbhc_pkg::CfgDataWidth{1'b1}});
    send_random_items(60);
    write_registers('0, 15'h4001, 15'h4000);
    send_random_items(120);
  endtask

  task automatic test_random_traffic();
    write_registers(15'd3, 15'd2, 15'd1);
    send_random_items(150);
    write_registers(15'd1, 15'd1, 15'd0);
    send_random_items(150);
    repeat (3) begin
      write_registers(cfg_data_t'($urandom_range(1, 8)), cfg_data_t'($urandom_range(1, 6)),
                      cfg_data_t'($urandom_range(0, 6)));
      send_random_items(100);
    end
  endtask

  // LED 1 is left past the end of a heartbeat cycle that a register write shortens.
  task automatic test_back_to_back();
    send_gaps = 1'b0;
    stall_gaps = 1'b0;
    write_registers(15'd1, cfg_data_t'(lbhc_pkg::PULSE_RESET),
                    cfg_data_t'(lbhc_pkg::PAUSE_RESET));
    send_item(lbhc_pkg::OP_BLINK, 2'd0, 16'd1);
    send_item(lbhc_pkg::OP_HEART, 2'd1, 16'd0);
    repeat (100) send_item(lbhc_pkg::OP_TICK, '0, '0);
    write_registers(15'd1, 15'd1, 15'd0);
    send_random_items(100);
    send_gaps = 1'b1;
    stall_gaps = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < NumLeds; i++) begin
      led_mode[i] = lbhc_pkg::MODE_IDLE;
      tick_cnt[i] = '0;
      repeat_cnt[i] = '0;
      repeat_goal[i] = '0;
      led_on[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_short_cycles();
    test_register_extremes();
    test_random_traffic();
    test_back_to_back();
    drain_results();
    if (fault_count == 0 && lit_expected_q.size() == 0) begin
      $display("[led_blink_heartbeat_controller] OK");
    end else begin
      $display("[led_blink_heartbeat_controller] ERROR");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("[led_blink_heartbeat_controller] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
hdl/lbhc_pkg.sv
hdl/led_blink_heartbeat_controller.sv
dv/led_blink_heartbeat_controller_tb.sv
